// ===== rtl/prp_pkg.sv =====
// prp_pkg: shared constants, codes and types of the page replacement policy engine
// no dependencies; used by every other file of the block
`default_nettype none

package prp_pkg;

    localparam int FRAMES     = 16;
    localparam int SLOT_W     = $clog2(FRAMES);
    localparam int RANK_W     = SLOT_W;
    localparam int NCNT_W     = 5;
    localparam int PAGE_W     = 8;
    localparam int CNT_W      = 16;
    localparam int POLICY_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [RANK_W-1:0]     t_rank;
    typedef logic [PAGE_W-1:0]     t_page;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [NCNT_W-1:0]     t_ncnt;
    typedef logic [POLICY_W-1:0]   t_policy;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_rank  RANK_MAX     = RANK_W'(FRAMES - 1);
    localparam t_count CNT_MAX      = '1;
    localparam t_ncnt  NCNT_FRAMES  = NCNT_W'(FRAMES);
    localparam t_ncnt  FRAMES_RESET = NCNT_W'(4);

    // replacement policy codes, the unused code behaves as fifo
    localparam t_policy POL_FIFO  = 2'd0;
    localparam t_policy POL_LRU   = 2'd1;
    localparam t_policy POL_CLOCK = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx REG_POLICY = CFG_IDX_W'(0);
    localparam t_cfg_idx REG_FRAMES = CFG_IDX_W'(1);

    // item action codes
    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_ACCESS = 1'b1;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load_in;
        logic search;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/prp_channels.sv =====
// prp_channels: valid/ready interfaces of the access, result and configuration channels
// depends on prp_pkg
`default_nettype none

interface prp_in_if;
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [prp_pkg::PAGE_W-1:0] page;
    modport source (output valid, action, page, input ready);
    modport sink   (input valid, action, page, output ready);
endinterface

interface prp_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [3:0]                 frame_slot;
    logic                       evicted_valid;
    logic [prp_pkg::PAGE_W-1:0] evicted_page;
    logic [prp_pkg::CNT_W-1:0]  fault_count;
    logic [prp_pkg::CNT_W-1:0]  access_count;
    modport source (output valid, hit, frame_slot, evicted_valid, evicted_page,
                    fault_count, access_count, input ready);
    modport sink   (input valid, hit, frame_slot, evicted_valid, evicted_page,
                    fault_count, access_count, output ready);
endinterface

interface prp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [prp_pkg::CFG_IDX_W-1:0]  index;
    logic [prp_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/prp_ctrl.sv =====
// prp_ctrl: sequencer of the engine, idle / search / commit, owns the result valid flag
// depends on prp_pkg
`default_nettype none

module prp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output prp_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_COMMIT) && w_out_free);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_in = w_accept;
        o_cmd.search  = (r_state == S_SEARCH);
        o_cmd.commit  = (r_state == S_COMMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a commit refills the result register, otherwise a taken result empties it
            if ((r_state == S_COMMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_out_free) begin
                        r_state <= w_accept ? S_SEARCH : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prp_datapath.sv =====
// prp_datapath: frame table, configuration registers, lookup and victim search, result register
// depends on prp_pkg; driven by the commands of prp_ctrl
`default_nettype none

module prp_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire prp_pkg::t_cmd        i_cmd,
    input  wire logic                 i_action,
    input  wire prp_pkg::t_page       i_page,
    input  wire logic                 i_cfg_we,
    input  wire prp_pkg::t_cfg_idx    i_cfg_index,
    input  wire prp_pkg::t_cfg_data   i_cfg_data,
    output logic                      o_hit,
    output logic [3:0]                o_frame_slot,
    output logic                      o_evicted_valid,
    output prp_pkg::t_page            o_evicted_page,
    output prp_pkg::t_count           o_fault_count,
    output prp_pkg::t_count           o_access_count
);

    localparam int F = prp_pkg::FRAMES;

    function automatic prp_pkg::t_slot first_set(input logic [F-1:0] v);
        prp_pkg::t_slot r;
        r = '0;
        for (int i = F - 1; i >= 0; i--) begin
            if (v[i]) r = prp_pkg::SLOT_W'(i);
        end
        return r;
    endfunction

    function automatic prp_pkg::t_slot next_slot(input prp_pkg::t_slot s,
                                                 input prp_pkg::t_ncnt n);
        prp_pkg::t_ncnt inc;
        inc = prp_pkg::NCNT_W'(s) + prp_pkg::NCNT_W'(1);
        return (inc >= n) ? '0 : prp_pkg::SLOT_W'(inc);
    endfunction

    function automatic prp_pkg::t_count sat_inc(input prp_pkg::t_count c);
        return (c == prp_pkg::CNT_MAX) ? c : c + prp_pkg::CNT_W'(1);
    endfunction

    // configuration and item registers
    prp_pkg::t_policy r_policy;
    prp_pkg::t_ncnt   r_frames;
    logic             r_action;
    prp_pkg::t_page   r_page;

    // frame table
    prp_pkg::t_page   r_resident [F];
    logic [F-1:0]     r_valid;
    logic [F-1:0]     r_ref;
    prp_pkg::t_rank   r_rank [F];
    prp_pkg::t_slot   r_hand;
    prp_pkg::t_slot   r_oldest;
    prp_pkg::t_count  r_fault_cnt;
    prp_pkg::t_count  r_access_cnt;

    // search results
    logic             r_s_hit;
    logic             r_s_fill;
    logic             r_s_evict;
    logic             r_s_fifo_adv;
    prp_pkg::t_slot   r_s_slot;
    prp_pkg::t_rank   r_s_old;
    prp_pkg::t_page   r_s_ev_page;
    logic [F-1:0]     r_s_clr;

    // result register
    logic             r_o_hit;
    prp_pkg::t_slot   r_o_slot;
    logic             r_o_ev_valid;
    prp_pkg::t_page   r_o_ev_page;
    prp_pkg::t_count  r_o_fault;
    prp_pkg::t_count  r_o_access;

    prp_pkg::t_ncnt   w_n;
    logic [F-1:0]     w_active;
    logic [F-1:0]     w_match;
    logic [F-1:0]     w_empty;
    logic [F-1:0]     w_cand;
    logic [F-1:0]     w_bitset;
    logic [F-1:0]     w_zero;
    logic [F-1:0]     w_hi;
    logic [F-1:0]     w_clk_clr;
    prp_pkg::t_slot   w_h;
    prp_pkg::t_slot   w_clk_slot;
    prp_pkg::t_slot   w_lru_slot;
    prp_pkg::t_slot   w_fifo_slot;
    prp_pkg::t_slot   w_victim;
    prp_pkg::t_slot   w_slot;
    logic             w_hit;
    logic             w_has_empty;
    logic             w_evict;

    // effective frame count, clamped to one..FRAMES
    always_comb begin
        if (r_frames == '0) begin
            w_n = prp_pkg::NCNT_W'(1);
        end else if (r_frames > prp_pkg::NCNT_FRAMES) begin
            w_n = prp_pkg::NCNT_FRAMES;
        end else begin
            w_n = r_frames;
        end
    end

    always_comb begin
        for (int i = 0; i < F; i++) begin
            w_active[i] = prp_pkg::NCNT_W'(i) < w_n;
            w_match[i]  = w_active[i] && r_valid[i] && (r_resident[i] == r_page);
            w_empty[i]  = w_active[i] && !r_valid[i];
        end
        w_hit       = |w_match;
        w_has_empty = |w_empty;
    end

    // lru: highest rank, one rank bit at a time from the top, lowest index on ties
    always_comb begin
        w_cand   = w_active;
        w_bitset = '0;
        for (int b = prp_pkg::RANK_W - 1; b >= 0; b--) begin
            for (int i = 0; i < F; i++) begin
                w_bitset[i] = w_cand[i] && r_rank[i][b];
            end
            if (|w_bitset) w_cand = w_bitset;
        end
        w_lru_slot = first_set(w_cand);
    end

    // clock: first clear reference bit from the hand onwards, wrapping at the count
    always_comb begin
        w_h = (prp_pkg::NCNT_W'(r_hand) >= w_n) ? '0 : r_hand;
        for (int i = 0; i < F; i++) begin
            w_zero[i] = w_active[i] && !r_ref[i];
            w_hi[i]   = prp_pkg::SLOT_W'(i) >= w_h;
        end
        if (|(w_zero & w_hi)) begin
            w_clk_slot = first_set(w_zero & w_hi);
            for (int i = 0; i < F; i++) begin
                w_clk_clr[i] = w_active[i] && w_hi[i] && (prp_pkg::SLOT_W'(i) < w_clk_slot);
            end
        end else if (|w_zero) begin
            w_clk_slot = first_set(w_zero);
            for (int i = 0; i < F; i++) begin
                w_clk_clr[i] = w_active[i] &&
                               (w_hi[i] || (prp_pkg::SLOT_W'(i) < w_clk_slot));
            end
        end else begin
            w_clk_slot = w_h;
            w_clk_clr  = w_active;
        end
    end

    always_comb begin
        w_fifo_slot = (prp_pkg::NCNT_W'(r_oldest) >= w_n) ? '0 : r_oldest;
        case (r_policy)
            prp_pkg::POL_LRU:   w_victim = w_lru_slot;
            prp_pkg::POL_CLOCK: w_victim = w_clk_slot;
            default:            w_victim = w_fifo_slot;
        endcase
        w_evict = !w_hit && !w_has_empty;
        if (w_hit) begin
            w_slot = first_set(w_match);
        end else if (w_has_empty) begin
            w_slot = first_set(w_empty);
        end else begin
            w_slot = w_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= prp_pkg::POL_FIFO;
            r_frames <= prp_pkg::FRAMES_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == prp_pkg::REG_POLICY) begin
                r_policy <= i_cfg_data[prp_pkg::POLICY_W-1:0];
            end else if (i_cfg_index == prp_pkg::REG_FRAMES) begin
                r_frames <= i_cfg_data[prp_pkg::NCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_page   <= i_page;
        end
        if (i_cmd.search) begin
            r_s_hit      <= w_hit;
            r_s_fill     <= !w_hit && w_has_empty;
            r_s_evict    <= w_evict;
            r_s_fifo_adv <= w_evict && (r_policy != prp_pkg::POL_LRU) &&
                            (r_policy != prp_pkg::POL_CLOCK);
            r_s_slot     <= w_slot;
            r_s_old      <= r_rank[w_slot];
            r_s_ev_page  <= r_resident[w_slot];
            r_s_clr      <= (w_evict && (r_policy == prp_pkg::POL_CLOCK)) ? w_clk_clr : '0;
        end
    end

    // resident pages, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_action == prp_pkg::ACT_ACCESS) && !r_s_hit) begin
            r_resident[r_s_slot] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_ref        <= '0;
            r_hand       <= '0;
            r_oldest     <= '0;
            r_fault_cnt  <= '0;
            r_access_cnt <= '0;
            for (int i = 0; i < F; i++) r_rank[i] <= '0;
        end else if (i_cmd.commit) begin
            if (r_action == prp_pkg::ACT_CLEAR) begin
                r_valid      <= '0;
                r_ref        <= '0;
                r_hand       <= '0;
                r_oldest     <= '0;
                r_fault_cnt  <= '0;
                r_access_cnt <= '0;
                for (int i = 0; i < F; i++) r_rank[i] <= '0;
            end else begin
                r_access_cnt <= sat_inc(r_access_cnt);
                for (int i = 0; i < F; i++) begin
                    if (prp_pkg::SLOT_W'(i) == r_s_slot) begin
                        r_rank[i] <= '0;
                    end else if (w_active[i] && r_valid[i] &&
                                 (r_s_fill || (r_rank[i] < r_s_old)) &&
                                 (r_rank[i] != prp_pkg::RANK_MAX)) begin
                        r_rank[i] <= r_rank[i] + prp_pkg::RANK_W'(1);
                    end
                end
                if (r_s_hit) begin
                    r_ref[r_s_slot] <= 1'b1;
                end else begin
                    r_fault_cnt       <= sat_inc(r_fault_cnt);
                    r_valid[r_s_slot] <= 1'b1;
                    for (int i = 0; i < F; i++) begin
                        if (prp_pkg::SLOT_W'(i) == r_s_slot) begin
                            r_ref[i] <= 1'b1;
                        end else if (r_s_clr[i]) begin
                            r_ref[i] <= 1'b0;
                        end
                    end
                    r_hand <= next_slot(r_s_slot, w_n);
                    if (r_s_fifo_adv) begin
                        r_oldest <= next_slot(r_s_slot, w_n);
                    end
                end
            end
        end
    end

    // result register, loaded as the item commits
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_action == prp_pkg::ACT_CLEAR) begin
                r_o_hit      <= 1'b0;
                r_o_slot     <= '0;
                r_o_ev_valid <= 1'b0;
                r_o_ev_page  <= '0;
                r_o_fault    <= '0;
                r_o_access   <= '0;
            end else begin
                r_o_hit      <= r_s_hit;
                r_o_slot     <= r_s_slot;
                r_o_ev_valid <= r_s_evict;
                r_o_ev_page  <= r_s_evict ? r_s_ev_page : '0;
                r_o_fault    <= r_s_hit ? r_fault_cnt : sat_inc(r_fault_cnt);
                r_o_access   <= sat_inc(r_access_cnt);
            end
        end
    end

    assign o_hit           = r_o_hit;
    assign o_frame_slot    = 4'(r_o_slot);
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;
    assign o_fault_count   = r_o_fault;
    assign o_access_count  = r_o_access;

endmodule

`default_nettype wire

// ===== rtl/page_replacement_policy_top.sv =====
// page_replacement_policy_top: page replacement engine (fifo, lru, clock) over a set of frames
// depends on prp_pkg, prp_channels, prp_ctrl and prp_datapath
//
//  channel  | dir | payload                                           | handshake
//  ---------+-----+---------------------------------------------------+------------
//  i_in     | in  | action, page                                      | valid/ready
//  o_out    | out | hit, frame_slot, evicted_valid, evicted_page,     | valid/ready
//           |     | fault_count, access_count                         |
//  i_cfg    | in  | index (0 policy, 1 frames_in_use), data           | valid/ready
//
// a result is registered after its item is taken: lookup and victim search over all frames into a
// search register, then a table update that loads the result register
// the next item is taken on the commit cycle of the current one, while the result register is free
// a result waits in the output register; only its commit stalls while that is still full
// synchronous active-low reset clears the frame table and counters, policy fifo, four frames
// configuration is always ready and is used by the search and commit of an item already taken
`default_nettype none

module page_replacement_policy_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    prp_in_if.sink     i_in,
    prp_out_if.source  o_out,
    prp_cfg_if.sink    i_cfg
);

    prp_pkg::t_cmd w_cmd;
    logic          w_in_ready;
    logic          w_out_valid;

    // configuration is taken at any time
    assign i_cfg.ready = 1'b1;

    // sequencer: handshakes and the idle / search / commit steps
    prp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // frame table, policies, counters and the result register
    prp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_in.action),
        .i_page          (i_in.page),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_hit           (o_out.hit),
        .o_frame_slot    (o_out.frame_slot),
        .o_evicted_valid (o_out.evicted_valid),
        .o_evicted_page  (o_out.evicted_page),
        .o_fault_count   (o_out.fault_count),
        .o_access_count  (o_out.access_count)
    );

endmodule

`default_nettype wire

// ===== rtl/prp_checker.sv =====
// prp_checker: port-level checks of the page replacement engine, bound to the top level
// depends on prp_pkg and page_replacement_policy_top
`default_nettype none

module prp_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire logic            i_hit,
    input wire logic            i_evicted_valid,
    input wire prp_pkg::t_page  i_evicted_page,
    input wire prp_pkg::t_count i_fault_count,
    input wire prp_pkg::t_count i_access_count
);

    // a held result keeps its hit flag, evicted page and fault count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hit) && $stable(i_evicted_page) &&
            $stable(i_fault_count))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken on the cycle after an accept");

    // a fresh result must have its item taken before it, with the item, search and result registers between them
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 3))
        else $error("result without a matching item");

    // faults never outnumber accesses, and a hit evicts nothing
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fault_count <= i_access_count) && !(i_hit && i_evicted_valid))
        else $error("inconsistent result fields");

endmodule

bind page_replacement_policy_top prp_checker u_prp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_hit           (o_out.hit),
    .i_evicted_valid (o_out.evicted_valid),
    .i_evicted_page  (o_out.evicted_page),
    .i_fault_count   (o_out.fault_count),
    .i_access_count  (o_out.access_count)
);

`default_nettype wire
